>>> rtl/vad_pkg.sv
// Shared widths, constants and data types for the vector angle pipeline.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package vad_pkg;

	// Input coordinate width and CORDIC depth
	localparam int COORD_WIDTH = 16;
	localparam int ITERATIONS  = 16;

	// Arithmetic sizing
	localparam int GUARD_BITS = 8;
	localparam int TABLE_LEN  = 24;
	localparam int NUM_CELLS  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
	localparam int MAG_W      = COORD_WIDTH + GUARD_BITS;
	localparam int XY_W       = MAG_W + 3;
	localparam int Z_W        = 25;
	localparam int A_W        = 26;
	localparam int SHIFT_W    = $clog2(TABLE_LEN);
	localparam int ANGLE_W    = 16;

	// Angles in degrees * 65536, results in degrees * 128
	localparam int DEG90_Q16  = 5898240;
	localparam int DEG180_Q16 = 11796480;
	localparam int DEG360_Q16 = 23592960;
	localparam int FULL_Q7    = 46080;
	localparam int DEG90_Q7   = 11520;
	localparam int DEG180_Q7  = 23040;
	localparam int DEG270_Q7  = 34560;
	localparam int ROUND_HALF = 256;
	localparam int ROUND_SHIFT = 9;

	// atan(2^-i) in degrees * 65536
	localparam int ATAN_Q16 [TABLE_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// Per-request side information carried down the chain
	typedef struct packed {
		logic                 special;
		logic [ANGLE_W-1:0]   spec_angle;
		logic                 x_neg;
		logic                 y_neg;
	} meta_t;

	// Data held by one cell
	typedef struct packed {
		logic signed [XY_W-1:0] cx;
		logic signed [XY_W-1:0] cy;
		logic signed [Z_W-1:0]  z;
		meta_t                  meta;
	} cell_t;

endpackage

>>> rtl/vad_prep.sv
// Entry stage: axis tests, quadrant folding and guard-bit scaling.
// Depends on vad_pkg.
`timescale 1ns / 1ps

module vad_prep (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   valid_in,
	input  logic signed [vad_pkg::COORD_WIDTH-1:0] x_coord,
	input  logic signed [vad_pkg::COORD_WIDTH-1:0] y_coord,
	output logic                                   valid_s0,
	output vad_pkg::cell_t                         data_s0
);

	localparam int CW  = vad_pkg::COORD_WIDTH;
	localparam int PAD = vad_pkg::XY_W - CW - 1 - vad_pkg::GUARD_BITS;

	logic signed [CW:0] xe, ye;
	logic [CW:0]        ax, ay;
	logic               x_zero, y_zero;
	vad_pkg::cell_t     nxt;

	// Fold into the first quadrant and flag vectors on an axis
	always_comb begin
		xe     = {x_coord[CW-1], x_coord};
		ye     = {y_coord[CW-1], y_coord};
		ax     = xe[CW] ? unsigned'(-xe) : unsigned'(xe);
		ay     = ye[CW] ? unsigned'(-ye) : unsigned'(ye);
		x_zero = (x_coord == '0);
		y_zero = (y_coord == '0);

		nxt.cx = $signed({{PAD{1'b0}}, ax, {vad_pkg::GUARD_BITS{1'b0}}});
		nxt.cy = $signed({{PAD{1'b0}}, ay, {vad_pkg::GUARD_BITS{1'b0}}});
		nxt.z  = '0;
		nxt.meta.special = x_zero || y_zero;
		nxt.meta.x_neg   = x_coord[CW-1];
		nxt.meta.y_neg   = y_coord[CW-1];
		priority if (x_zero && y_zero) begin
			nxt.meta.spec_angle = '0;
		end else if (x_zero) begin
			nxt.meta.spec_angle = y_coord[CW-1] ? vad_pkg::ANGLE_W'(vad_pkg::DEG270_Q7)
			                                    : vad_pkg::ANGLE_W'(vad_pkg::DEG90_Q7);
		end else if (y_zero) begin
			nxt.meta.spec_angle = x_coord[CW-1] ? vad_pkg::ANGLE_W'(vad_pkg::DEG180_Q7)
			                                    : '0;
		end else begin
			nxt.meta.spec_angle = '0;
		end
	end

	// Hold valid under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= valid_in;
		end
	end

	// Capture payload on advance
	always_ff @(posedge clk) begin
		if (adv) begin
			data_s0 <= nxt;
		end
	end

endmodule

>>> rtl/vad_cell.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on vad_pkg.
`timescale 1ns / 1ps

module vad_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [vad_pkg::SHIFT_W-1:0]        shift,
	input  logic signed [vad_pkg::Z_W-1:0]     atan_step,
	input  logic                               valid_in,
	input  vad_pkg::cell_t                     data_in,
	output logic                               valid_out,
	output vad_pkg::cell_t                     data_out
);

	logic signed [vad_pkg::XY_W-1:0] dx, dy;
	vad_pkg::cell_t                  nxt;

	// Rotate toward the x axis by the sign of y
	always_comb begin
		dx       = data_in.cy >>> shift;
		dy       = data_in.cx >>> shift;
		nxt.meta = data_in.meta;
		if (!data_in.cy[vad_pkg::XY_W-1]) begin
			nxt.cx = data_in.cx + dx;
			nxt.cy = data_in.cy - dy;
			nxt.z  = data_in.z + atan_step;
		end else begin
			nxt.cx = data_in.cx - dx;
			nxt.cy = data_in.cy + dy;
			nxt.z  = data_in.z - atan_step;
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= valid_in;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			data_out <= nxt;
		end
	end

endmodule

>>> rtl/vad_post.sv
// Exit stage: clamp, quadrant restore, rounding to degrees * 128, output register.
// Depends on vad_pkg.
`timescale 1ns / 1ps

module vad_post (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_in,
	input  vad_pkg::cell_t                data_in,
	output logic                          out_valid,
	output logic [vad_pkg::ANGLE_W-1:0]   angle_deg_q7
);

	localparam int QW = vad_pkg::A_W - vad_pkg::ROUND_SHIFT;

	logic signed [vad_pkg::Z_W-1:0] phi;
	logic [vad_pkg::A_W-1:0]        a, ar;
	logic [QW-1:0]                  q7, q7w;
	logic [vad_pkg::ANGLE_W-1:0]    nxt;

	// Clamp to [0, 90] degrees and restore the quadrant
	always_comb begin
		priority if (data_in.z[vad_pkg::Z_W-1]) begin
			phi = '0;
		end else if (data_in.z > vad_pkg::Z_W'(vad_pkg::DEG90_Q16)) begin
			phi = vad_pkg::Z_W'(vad_pkg::DEG90_Q16);
		end else begin
			phi = data_in.z;
		end

		unique case ({data_in.meta.x_neg, data_in.meta.y_neg})
			2'b00:   a = vad_pkg::A_W'(phi);
			2'b10:   a = vad_pkg::A_W'(vad_pkg::DEG180_Q16) - vad_pkg::A_W'(phi);
			2'b11:   a = vad_pkg::A_W'(vad_pkg::DEG180_Q16) + vad_pkg::A_W'(phi);
			default: a = vad_pkg::A_W'(vad_pkg::DEG360_Q16) - vad_pkg::A_W'(phi);
		endcase

		// Round half up, wrap a full circle to zero
		ar  = a + vad_pkg::A_W'(vad_pkg::ROUND_HALF);
		q7  = ar[vad_pkg::A_W-1:vad_pkg::ROUND_SHIFT];
		q7w = (q7 >= QW'(vad_pkg::FULL_Q7)) ? q7 - QW'(vad_pkg::FULL_Q7) : q7;
		nxt = data_in.meta.special ? data_in.meta.spec_angle
		                           : q7w[vad_pkg::ANGLE_W-1:0];
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_deg_q7 <= nxt;
		end
	end

endmodule

>>> rtl/vector_angle_degrees.sv
// Pipeline: entry stage, one cell per micro-rotation, and the exit stage with the
// output register.
// Throughput: one request per cycle; the whole chain moves together and halts
// only while the output register holds a result that is not taken.
// Reset: arst_n clears every stage valid bit at once; payload is not reset.
`timescale 1ns / 1ps

module vector_angle_degrees (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [vad_pkg::COORD_WIDTH-1:0] x_coord,
	input  logic signed [vad_pkg::COORD_WIDTH-1:0] y_coord,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [vad_pkg::ANGLE_W-1:0]            angle_deg_q7
);

	localparam int N = vad_pkg::NUM_CELLS;

	logic           adv;
	logic           cvalid [N+1];
	vad_pkg::cell_t cdata  [N+1];

	// Advance whenever the output register is free or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	vad_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_in (in_valid),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.valid_s0 (cvalid[0]),
		.data_s0  (cdata[0])
	);

	// Chain of micro-rotation cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		vad_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.shift     (vad_pkg::SHIFT_W'(i)),
			.atan_step (vad_pkg::Z_W'(vad_pkg::ATAN_Q16[i])),
			.valid_in  (cvalid[i]),
			.data_in   (cdata[i]),
			.valid_out (cvalid[i+1]),
			.data_out  (cdata[i+1])
		);
	end

	vad_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_in     (cvalid[N]),
		.data_in      (cdata[N]),
		.out_valid    (out_valid),
		.angle_deg_q7 (angle_deg_q7)
	);

	// An accepted request reaches the entry stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cvalid[0])
		else $error("accepted request lost at entry stage");

	// The last cell always hands its request to the output register
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cvalid[N]) |=> out_valid)
		else $error("request dropped at exit stage");

	// A stalled output blocks new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while output stalled");

	// Results stay below a full circle
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_deg_q7 < vad_pkg::ANGLE_W'(vad_pkg::FULL_Q7)))
		else $error("angle out of range");

endmodule

>>> tb/tb_vector_angle_degrees.sv
// Self-checking testbench for vector_angle_degrees: a queue-fed driver, a monitor,
// and a bit-exact CORDIC angle predictor. Depends on rtl/vad_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_vector_angle_degrees;

	import vad_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int ERR_SHOWN    = 10;
	localparam int RANDOM_VECS  = 400;

	// atan(2^-i) in degrees * 65536, kept apart from the design's own table
	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} vec_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic [ANGLE_W-1:0]            angle;
	} angle_exp_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [COORD_WIDTH-1:0] x_coord   = '0;
	logic signed [COORD_WIDTH-1:0] y_coord   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ANGLE_W-1:0]            angle_deg_q7;

	vec_t       vec_queue[$];
	angle_exp_t angle_queue[$];
	angle_exp_t head_exp;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_zero      = 0;
	int errors      = 0;
	int cycle_cnt   = 0;

	vector_angle_degrees DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.angle_deg_q7 (angle_deg_q7)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Angle of (x, y) in degrees * 128 over [0, 360)
	function automatic logic [ANGLE_W-1:0] predict_angle_q7(
		logic signed [COORD_WIDTH-1:0] x, logic signed [COORD_WIDTH-1:0] y);
		longint sx, sy, cx, cy, dx, dy, z, a, q7;
		int     steps;
		sx = x;
		sy = y;
		if (sx == 0 && sy == 0)
			return '0;
		if (sx == 0)
			return (sy > 0) ? ANGLE_W'(DEG90_Q7) : ANGLE_W'(DEG270_Q7);
		if (sy == 0)
			return (sx > 0) ? '0 : ANGLE_W'(DEG180_Q7);

		// fold into the first quadrant and rotate onto the x axis
		cx = ((sx < 0) ? -sx : sx) <<< GUARD_BITS;
		cy = ((sy < 0) ? -sy : sy) <<< GUARD_BITS;
		z = 0;
		steps = (ITERATIONS < 24) ? ITERATIONS : 24;
		for (int i = 0; i < steps; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + ATAN_DEG_Q16[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - ATAN_DEG_Q16[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > DEG90_Q16)
			z = DEG90_Q16;

		// restore the quadrant, round half up, wrap a full turn to zero
		if (sx > 0 && sy > 0)
			a = z;
		else if (sx < 0 && sy > 0)
			a = DEG180_Q16 - z;
		else if (sx < 0)
			a = DEG180_Q16 + z;
		else
			a = DEG360_Q16 - z;
		q7 = (a + ROUND_HALF) >>> ROUND_SHIFT;
		if (q7 >= FULL_Q7)
			q7 = q7 - FULL_Q7;
		return q7[ANGLE_W-1:0];
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] pick_extreme();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return 16'sh7fff;
		endcase
	endfunction

	task automatic push_vec(int x, int y);
		vec_t v;
		v.x = clamp_coord(x);
		v.y = clamp_coord(y);
		vec_queue.push_back(v);
	endtask

	// Mix of full-range vectors and ones aimed at axes, diagonals and corners
	task automatic push_random_vector();
		int   mx, my, t;
		vec_t v;
		mx = $signed(16'($urandom));
		my = $signed(16'($urandom));
		case ($urandom_range(9))
			4: begin
				mx = int'($urandom_range(16)) - 8;
				my = int'($urandom_range(16)) - 8;
			end
			5: begin
				if ($urandom_range(1))
					mx = 0;
				else
					my = 0;
			end
			6: begin
				mx = pick_extreme();
				my = pick_extreme();
			end
			7: begin
				my = mx + int'($urandom_range(8)) - 4;
				if ($urandom_range(1))
					my = -my;
			end
			8: my = int'($urandom_range(6)) - 3;
			9: mx = int'($urandom_range(6)) - 3;
			default: begin
			end
		endcase
		if ($urandom_range(3) == 0) begin
			t = mx;
			mx = my;
			my = t;
		end
		v.x = clamp_coord(mx);
		v.y = clamp_coord(my);
		vec_queue.push_back(v);
	endtask

	// Hold until every queued request is sent and every angle has come back
	task automatic wait_drained();
		while (vec_queue.size() > 0 || in_valid || angle_queue.size() > 0)
			@(negedge clk);
	endtask

	// Driver: record accepted requests, present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			x_coord  <= '0;
			y_coord  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				angle_queue.push_back('{x_coord, y_coord, predict_angle_q7(x_coord, y_coord)});
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (vec_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_valid <= 1'b1;
					x_coord  <= vec_queue[0].x;
					y_coord  <= vec_queue[0].y;
					vec_queue.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each delivered angle with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (angle_queue.size() == 0) begin
					errors++;
					if (errors <= ERR_SHOWN)
						$display("ERROR: unexpected angle %0d with nothing pending",
							angle_deg_q7);
				end else begin
					head_exp = angle_queue.pop_front();
					n_checked++;
					if (head_exp.angle == 0)
						n_zero++;
					if (angle_deg_q7 !== head_exp.angle) begin
						errors++;
						if (errors <= ERR_SHOWN)
							$display("ERROR: x=%0d y=%0d angle expected %0d got %0d",
								head_exp.x, head_exp.y, head_exp.angle, angle_deg_q7);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d angles pending", cycle_cnt,
				angle_queue.size());
			$display("vector_angle_degrees: mismatch");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 36;
		rx_idle_pct = 80;

		// axes, the origin, corners, unit diagonals, and near-axis vectors
		// that round to a full turn or straddle 180 degrees
		push_vec(0, 0);
		push_vec(1, 0);
		push_vec(-1, 0);
		push_vec(0, 1);
		push_vec(0, -1);
		push_vec(32767, 0);
		push_vec(-32768, 0);
		push_vec(0, 32767);
		push_vec(0, -32768);
		push_vec(32767, 32767);
		push_vec(-32768, -32768);
		push_vec(32767, -32768);
		push_vec(-32768, 32767);
		push_vec(1, 1);
		push_vec(-1, 1);
		push_vec(-1, -1);
		push_vec(1, -1);
		push_vec(32767, 1);
		push_vec(32767, -1);
		push_vec(-32768, 1);
		push_vec(-32768, -1);
		push_vec(1, 32767);
		push_vec(1, -32768);
		push_vec(-1, -32768);

		// let the pipeline empty completely before the random traffic
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 36;
					rx_idle_pct = 80;
				end
				1: begin
					tx_idle_pct = 80;
					rx_idle_pct = 36;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_VECS) push_random_vector();
			while (vec_queue.size() > 0)
				@(negedge clk);
		end

		wait_drained();
		repeat (NUM_CELLS + 6) @(negedge clk);

		$display("checked %0d angles from %0d vectors (%0d at zero degrees) across",
			n_checked, n_sent, n_zero);
		$display("axis, corner, full-turn rounding and random vectors under three stall mixes");
		if (errors == 0)
			$display("vector_angle_degrees: match");
		else
			$display("vector_angle_degrees: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/vad_pkg.sv
rtl/vad_prep.sv
rtl/vad_cell.sv
rtl/vad_post.sv
rtl/vector_angle_degrees.sv
tb/tb_vector_angle_degrees.sv
